// ===== src/camera_ray_direction_top_defines.svh =====
// Assertion macros shared by the camera ray direction block.
`ifndef CAMERA_RAY_DIRECTION_TOP_DEFINES_SVH
`define CAMERA_RAY_DIRECTION_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked while out of reset
`define CRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included
`define CRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRD_ASSERT(lbl, prop, msg)
`define CRD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/crd_pkg.sv =====
// Types and constants of the camera ray direction block.
package crd_pkg;

  localparam int CRD_PIX_W          = 12;
  localparam int CRD_COMPONENT_BITS = 21;
  localparam int CRD_STEP_W         = 32;
  localparam int CRD_VEC_W          = 63;
  localparam int CRD_DATA_W         = 64;
  localparam int CRD_ADDR_W         = 6;
  localparam int CRD_DIR_W          = 16;
  // the largest normalized magnitude lies in [2^29, 2^30)
  localparam int CRD_NORM_MSB       = 29;
  localparam int CRD_NORM_W         = CRD_NORM_MSB + 1;
  localparam int CRD_SQ_W           = 64;
  localparam int CRD_SQ_ITERS       = 32;
  localparam int CRD_LEN_W          = 31;
  localparam int CRD_Q_BITS         = 16;
  localparam int CRD_REM_W          = CRD_NORM_W + 15 + 1;

  typedef enum logic [2:0] {
    REG_ULC   = 3'd0,
    REG_POS   = 3'd1,
    REG_RAX   = 3'd2,
    REG_UAX   = 3'd3,
    REG_HSTEP = 3'd4,
    REG_VSTEP = 3'd5
  } crd_reg_t;

  typedef struct packed {
    logic [CRD_PIX_W-1:0] pixel_column;
    logic [CRD_PIX_W-1:0] pixel_row;
  } crd_in_t;

  typedef struct packed {
    logic signed [CRD_DIR_W-1:0] dir_x;
    logic signed [CRD_DIR_W-1:0] dir_y;
    logic signed [CRD_DIR_W-1:0] dir_z;
    logic                        degenerate;
  } crd_out_t;

  // what rides along the root and divide stages
  typedef struct packed {
    logic [2:0][CRD_NORM_W-1:0] mag;
    logic [2:0]                 neg;
    logic                       zero;
  } crd_side_t;

endpackage

// ===== src/camera_ray_direction_top.sv =====
// Pinhole camera primary ray direction generator, fully pipelined.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------------------
//  input   | start, busy, in_data                    | beat when start && !busy
//  result  | out_valid, out_data                     | one-cycle strobe, no stall
//  config  | psel penable pwrite paddr pwdata prdata | write at access, pready = 1
//
// One pixel enters per clock; busy is always low. The pipeline has
// 7 setup stages, 32 square-root stages (one root bit each), 1 rounding stage,
// 16 divide stages (one quotient bit each, three lanes) and the output register.
// Synchronous reset clears the valid bits and the configuration registers; nothing stalls.
`include "camera_ray_direction_top_defines.svh"

module camera_ray_direction_top
  import crd_pkg::*;
#(
  parameter int COMPONENT_BITS = CRD_COMPONENT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  crd_in_t               in_data,
  output logic                  out_valid,
  output crd_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CRD_ADDR_W-1:0] paddr,
  input  logic [CRD_DATA_W-1:0] pwdata,
  output logic [CRD_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int C     = COMPONENT_BITS;
  localparam int PROD_W = CRD_STEP_W + CRD_PIX_W;
  localparam int SC_W  = PROD_W - 8;
  localparam int PR_W  = C + SC_W + 1;
  localparam int V_W   = PR_W + 2;
  localparam int MSB_W = $clog2(V_W);
  localparam int LAT   = 7 + CRD_SQ_ITERS + 1 + CRD_Q_BITS + 1;

  // ---------------- configuration registers ----------------
  logic [CRD_VEC_W-1:0]  ulc_r, pos_r, rax_r, uax_r;
  logic [CRD_STEP_W-1:0] hstep_r, vstep_r;
  logic                  wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ulc_r   <= '0;
      pos_r   <= '0;
      rax_r   <= '0;
      uax_r   <= '0;
      hstep_r <= '0;
      vstep_r <= '0;
    end else if (wr_en) begin
      case (crd_reg_t'(paddr[5:3]))
        REG_ULC:   ulc_r   <= pwdata[CRD_VEC_W-1:0];
        REG_POS:   pos_r   <= pwdata[CRD_VEC_W-1:0];
        REG_RAX:   rax_r   <= pwdata[CRD_VEC_W-1:0];
        REG_UAX:   uax_r   <= pwdata[CRD_VEC_W-1:0];
        REG_HSTEP: hstep_r <= pwdata[CRD_STEP_W-1:0];
        REG_VSTEP: vstep_r <= pwdata[CRD_STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    case (crd_reg_t'(paddr[5:3]))
      REG_ULC:   prdata = {1'b0, ulc_r};
      REG_POS:   prdata = {1'b0, pos_r};
      REG_RAX:   prdata = {1'b0, rax_r};
      REG_UAX:   prdata = {1'b0, uax_r};
      REG_HSTEP: prdata = {{(CRD_DATA_W-CRD_STEP_W){1'b0}}, hstep_r};
      REG_VSTEP: prdata = {{(CRD_DATA_W-CRD_STEP_W){1'b0}}, vstep_r};
      default:   prdata = '0;
    endcase
  end

  // ---------------- stage 1: step products, corner offset ----------------
  logic                    v1_r;
  logic [SC_W-1:0]         sc_r, sr_r;
  logic signed [C:0]       diff_r [3];
  logic [PROD_W-1:0]       scp_nxt, srp_nxt;
  logic signed [C:0]       diff_nxt [3];

  always_comb begin
    scp_nxt = PROD_W'(hstep_r * in_data.pixel_column) + PROD_W'(128);
    srp_nxt = PROD_W'(vstep_r * in_data.pixel_row) + PROD_W'(128);
    for (int k = 0; k < 3; k++) begin
      diff_nxt[k] = $signed({ulc_r[k*C+C-1], ulc_r[k*C +: C]})
                  - $signed({pos_r[k*C+C-1], pos_r[k*C +: C]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start && !busy;
    sc_r <= scp_nxt[PROD_W-1:8];
    sr_r <= srp_nxt[PROD_W-1:8];
    for (int k = 0; k < 3; k++) diff_r[k] <= diff_nxt[k];
  end

  // ---------------- stage 2: axis products ----------------
  logic                   v2_r;
  logic signed [PR_W-1:0] pr_r [3];
  logic signed [PR_W-1:0] pu_r [3];
  logic signed [C:0]      diff2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    for (int k = 0; k < 3; k++) begin
      pr_r[k]    <= $signed(rax_r[k*C +: C]) * $signed({1'b0, sc_r});
      pu_r[k]    <= $signed(uax_r[k*C +: C]) * $signed({1'b0, sr_r});
      diff2_r[k] <= diff_r[k];
    end
  end

  // ---------------- stage 3: vector sum, sign and magnitude ----------------
  logic                  v3_r;
  logic [V_W-1:0]        mag_r [3];
  logic [2:0]            neg_r;
  logic signed [V_W-1:0] vec_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vec_nxt[k] = $signed({diff2_r[k], 16'b0}) + pr_r[k] - pu_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    for (int k = 0; k < 3; k++) begin
      neg_r[k] <= vec_nxt[k][V_W-1];
      mag_r[k] <= vec_nxt[k][V_W-1] ? V_W'(-vec_nxt[k]) : V_W'(vec_nxt[k]);
    end
  end

  // ---------------- stage 4: leading one of the largest magnitude ----------------
  // the top bit of the OR equals the top bit of the maximum
  logic             v4_r;
  logic [V_W-1:0]   mag4_r [3];
  logic [2:0]       neg4_r;
  logic [MSB_W-1:0] msb_r;
  logic             zero4_r;
  logic [V_W-1:0]   orv;
  logic [MSB_W-1:0] msb_nxt;

  always_comb begin
    orv     = mag_r[0] | mag_r[1] | mag_r[2];
    msb_nxt = '0;
    for (int i = 0; i < V_W; i++) begin
      if (orv[i]) msb_nxt = MSB_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    for (int k = 0; k < 3; k++) mag4_r[k] <= mag_r[k];
    neg4_r  <= neg_r;
    msb_r   <= msb_nxt;
    zero4_r <= (orv == '0);
  end

  // ---------------- stage 5: common normalizing shift ----------------
  logic      v5_r;
  crd_side_t side5_r;
  logic [V_W-1:0] shv [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (msb_r > MSB_W'(CRD_NORM_MSB)) shv[k] = mag4_r[k] >> (msb_r - MSB_W'(CRD_NORM_MSB));
      else                              shv[k] = mag4_r[k] << (MSB_W'(CRD_NORM_MSB) - msb_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
    for (int k = 0; k < 3; k++) side5_r.mag[k] <= shv[k][CRD_NORM_W-1:0];
    side5_r.neg  <= neg4_r;
    side5_r.zero <= zero4_r;
  end

  // ---------------- stage 6: squares ----------------
  logic                      v6_r;
  crd_side_t                 side6_r;
  logic [2*CRD_NORM_W-1:0]   sqr_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else        v6_r <= v5_r;
    for (int k = 0; k < 3; k++) sqr_r[k] <= side5_r.mag[k] * side5_r.mag[k];
    side6_r <= side5_r;
  end

  // ---------------- stage 7: sum of squares ----------------
  logic                v7_r;
  crd_side_t           side7_r;
  logic [CRD_SQ_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else        v7_r <= v6_r;
    sum_r   <= CRD_SQ_W'(sqr_r[0]) + CRD_SQ_W'(sqr_r[1]) + CRD_SQ_W'(sqr_r[2]);
    side7_r <= side6_r;
  end

  // ---------------- square root: one result bit per stage ----------------
  logic                sq_v_r    [1:CRD_SQ_ITERS];
  logic [CRD_SQ_W-1:0] sq_n_r    [1:CRD_SQ_ITERS];
  logic [CRD_SQ_W-1:0] sq_root_r [1:CRD_SQ_ITERS];
  crd_side_t           sq_side_r [1:CRD_SQ_ITERS];

  for (genvar s = 0; s < CRD_SQ_ITERS; s++) begin : g_sqrt
    logic                vin;
    logic [CRD_SQ_W-1:0] nin, rin, trial, bitv;
    crd_side_t           sin;
    if (s == 0) begin : g_first
      assign vin = v7_r;
      assign nin = sum_r;
      assign rin = '0;
      assign sin = side7_r;
    end else begin : g_rest
      assign vin = sq_v_r[s];
      assign nin = sq_n_r[s];
      assign rin = sq_root_r[s];
      assign sin = sq_side_r[s];
    end
    assign bitv  = CRD_SQ_W'(1) << (2 * (CRD_SQ_ITERS - 1 - s));
    assign trial = rin + bitv;

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[s+1] <= 1'b0;
      else        sq_v_r[s+1] <= vin;
      if (nin >= trial) begin
        sq_n_r[s+1]    <= nin - trial;
        sq_root_r[s+1] <= (rin >> 1) + bitv;
      end else begin
        sq_n_r[s+1]    <= nin;
        sq_root_r[s+1] <= rin >> 1;
      end
      sq_side_r[s+1] <= sin;
    end
  end

  // ---------------- rounding stage: dividends ----------------
  logic                 dv0_r;
  crd_side_t            dside0_r;
  logic [CRD_LEN_W-1:0] len0_r;
  logic [CRD_REM_W-1:0] rem0_r [3];
  logic [CRD_LEN_W-1:0] len_nxt;

  assign len_nxt = sq_root_r[CRD_SQ_ITERS][CRD_LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) dv0_r <= 1'b0;
    else        dv0_r <= sq_v_r[CRD_SQ_ITERS];
    len0_r   <= len_nxt;
    dside0_r <= sq_side_r[CRD_SQ_ITERS];
    for (int k = 0; k < 3; k++) begin
      rem0_r[k] <= CRD_REM_W'({sq_side_r[CRD_SQ_ITERS].mag[k], 15'b0})
                 + CRD_REM_W'(len_nxt >> 1);
    end
  end

  // ---------------- divide: one quotient bit per stage, three lanes ----------------
  logic                  dv_r   [1:CRD_Q_BITS];
  crd_side_t             dside_r[1:CRD_Q_BITS];
  logic [CRD_LEN_W-1:0]  dlen_r [1:CRD_Q_BITS];
  logic [CRD_REM_W-1:0]  drem_r [1:CRD_Q_BITS][3];
  logic [CRD_Q_BITS-1:0] dq_r   [1:CRD_Q_BITS][3];

  for (genvar s = 0; s < CRD_Q_BITS; s++) begin : g_div
    logic                  vin;
    crd_side_t             sin;
    logic [CRD_LEN_W-1:0]  lin;
    logic [CRD_REM_W-1:0]  rin [3];
    logic [CRD_Q_BITS-1:0] qin [3];
    logic [CRD_REM_W:0]    dsh;
    if (s == 0) begin : g_first
      assign vin = dv0_r;
      assign sin = dside0_r;
      assign lin = len0_r;
      for (genvar k = 0; k < 3; k++) begin : g_l
        assign rin[k] = rem0_r[k];
        assign qin[k] = '0;
      end
    end else begin : g_rest
      assign vin = dv_r[s];
      assign sin = dside_r[s];
      assign lin = dlen_r[s];
      for (genvar k = 0; k < 3; k++) begin : g_l
        assign rin[k] = drem_r[s][k];
        assign qin[k] = dq_r[s][k];
      end
    end
    assign dsh = (CRD_REM_W+1)'(lin) << (CRD_Q_BITS - 1 - s);

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[s+1] <= 1'b0;
      else        dv_r[s+1] <= vin;
      dside_r[s+1] <= sin;
      dlen_r[s+1]  <= lin;
      for (int k = 0; k < 3; k++) begin
        if ({1'b0, rin[k]} >= dsh) begin
          drem_r[s+1][k] <= CRD_REM_W'({1'b0, rin[k]} - dsh);
          dq_r[s+1][k]   <= qin[k] | (CRD_Q_BITS'(1) << (CRD_Q_BITS - 1 - s));
        end else begin
          drem_r[s+1][k] <= rin[k];
          dq_r[s+1][k]   <= qin[k];
        end
      end
    end
  end

  // ---------------- output: sign, saturation, degenerate ----------------
  logic [CRD_DIR_W-1:0] dir_nxt [3];
  crd_side_t            fside;

  assign fside = dside_r[CRD_Q_BITS];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (fside.zero) begin
        dir_nxt[k] = '0;
      end else if (fside.neg[k]) begin
        // quotient never exceeds one, so -1 is reachable and fits
        dir_nxt[k] = CRD_DIR_W'(-dq_r[CRD_Q_BITS][k]);
      end else if (dq_r[CRD_Q_BITS][k][CRD_Q_BITS-1]) begin
        dir_nxt[k] = {1'b0, {(CRD_DIR_W-1){1'b1}}};
      end else begin
        dir_nxt[k] = dq_r[CRD_Q_BITS][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= dv_r[CRD_Q_BITS];
    out_data.dir_x      <= dir_nxt[0];
    out_data.dir_y      <= dir_nxt[1];
    out_data.dir_z      <= dir_nxt[2];
    out_data.degenerate <= fside.zero;
  end

  // ---------------- checks ----------------
  `CRD_ASSERT(a_latency, (start && !busy) |-> ##LAT out_valid, "result beat missing")
  `CRD_ASSERT(a_degen_zero,
    (out_valid && out_data.degenerate) |->
      (out_data.dir_x == '0 && out_data.dir_y == '0 && out_data.dir_z == '0),
    "degenerate beat carries a nonzero direction")
  `CRD_ASSERT_ALWAYS(a_reset_flush, !rst_n |=> !out_valid, "result beat right after reset")

endmodule

// ===== dv/crd_ray_checker.sv =====
// Checker for the ray direction block: predicts each beat and compares results.
module crd_ray_checker
  import crd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  crd_in_t               in_data,
  input  logic                  out_valid,
  input  crd_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CRD_ADDR_W-1:0] paddr,
  input  logic [CRD_DATA_W-1:0] pwdata,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the camera registers
  logic [CRD_VEC_W-1:0]  corner_q, origin_q, right_q, up_q;
  logic [CRD_STEP_W-1:0] hstep_q, vstep_q;
  crd_out_t              ray_q[$];

  // signed Q10.10 component k of a packed vector
  function automatic longint vec_comp(logic [CRD_VEC_W-1:0] vec, int k);
    logic signed [CRD_COMPONENT_BITS-1:0] c;
    c = vec[k*CRD_COMPONENT_BITS +: CRD_COMPONENT_BITS];
    return longint'(c);
  endfunction

  // bitwise integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // unit ray direction for one pixel under the current registers
  function automatic crd_out_t ray_direction(crd_in_t px);
    longint          sc, sr, v;
    longint unsigned mag[3];
    bit              neg[3];
    longint unsigned top, t, sum, len, q;
    int              msb;
    logic [15:0]     d[3];
    crd_out_t        r;
    sc = longint'((64'(hstep_q) * 64'(px.pixel_column) + 64'd128) >> 8);
    sr = longint'((64'(vstep_q) * 64'(px.pixel_row) + 64'd128) >> 8);
    top = 0;
    for (int k = 0; k < 3; k++) begin
      v = (vec_comp(corner_q, k) - vec_comp(origin_q, k)) * 65536
          + vec_comp(right_q, k) * sc - vec_comp(up_q, k) * sr;
      neg[k] = v < 0;
      mag[k] = neg[k] ? longint'(-v) : longint'(v);
      if (mag[k] > top) top = mag[k];
    end
    r = '0;
    if (top == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    msb = 0;
    t = top;
    while (t > 1) begin
      t = t >> 1;
      msb++;
    end
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      if (msb > CRD_NORM_MSB) mag[k] = mag[k] >> (msb - CRD_NORM_MSB);
      else mag[k] = mag[k] << (CRD_NORM_MSB - msb);
      sum += mag[k] * mag[k];
    end
    len = int_sqrt(sum);
    for (int k = 0; k < 3; k++) begin
      q = (mag[k] * 64'd32768 + (len >> 1)) / len;
      if (neg[k]) begin
        if (q > 32768) q = 32768;
        d[k] = 16'(-longint'(q));
      end else begin
        if (q > 32767) q = 32767;
        d[k] = 16'(q);
      end
    end
    r.dir_x = d[0];
    r.dir_y = d[1];
    r.dir_z = d[2];
    return r;
  endfunction

  // register writes, input beats and result beats
  always @(posedge clk) begin
    crd_out_t want;
    if (!rst_n) begin
      corner_q <= '0; origin_q <= '0; right_q <= '0; up_q <= '0;
      hstep_q <= '0; vstep_q <= '0;
      errors <= 0;
      pending <= 0;
      ray_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr >> 3)
          REG_ULC:   corner_q <= pwdata[CRD_VEC_W-1:0];
          REG_POS:   origin_q <= pwdata[CRD_VEC_W-1:0];
          REG_RAX:   right_q  <= pwdata[CRD_VEC_W-1:0];
          REG_UAX:   up_q     <= pwdata[CRD_VEC_W-1:0];
          REG_HSTEP: hstep_q  <= pwdata[CRD_STEP_W-1:0];
          REG_VSTEP: vstep_q  <= pwdata[CRD_STEP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (ray_q.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, out_data);
          errors <= errors + 1;
        end else begin
          want = ray_q.pop_front();
          if (out_data.dir_x !== want.dir_x || out_data.dir_y !== want.dir_y ||
              out_data.dir_z !== want.dir_z || out_data.degenerate !== want.degenerate) begin
            $display("%0t: ray expected %p actual %p", $time, want, out_data);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) ray_q.push_back(ray_direction(in_data));
      // rays still owed by the block
      pending <= ray_q.size();
    end
  end
endmodule

// ===== dv/tb_camera_ray_direction_top.sv =====
// Testbench top: clock, reset, register setup and pixel stimulus, verdict.
module tb_camera_ray_direction_top
  import crd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BAD_REG_IDX = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PIX_MAX = (1 << CRD_PIX_W) - 1;

  logic                  clk, rst_n, start, busy, out_valid;
  crd_in_t               in_data;
  crd_out_t              out_data;
  logic                  psel, penable, pwrite, pready;
  logic [CRD_ADDR_W-1:0] paddr;
  logic [CRD_DATA_W-1:0] pwdata, prdata;
  int                    errors, pending, cycles;
  bit                    no_gaps;

  camera_ray_direction_top u_dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  crd_ray_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("camera_ray_direction_top: mismatch");
        $finish;
      end
    end
  end

  function automatic logic [63:0] pack_vec(int x, int y, int z);
    return {1'b0, 21'(z), 21'(y), 21'(x)};
  endfunction

  // register write: setup phase, then access phase
  task automatic reg_write(int idx, logic [63:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= CRD_ADDR_W'(idx * 8); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one pixel beat, then an optional idle gap
  task automatic send_pixel(int col, int row);
    bit b;
    int gap;
    start <= 1'b1;
    in_data <= '{pixel_column: CRD_PIX_W'(col), pixel_row: CRD_PIX_W'(row)};
    do begin
      @(negedge clk);
      b = busy;
      @(posedge clk);
    end while (b);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until every ray is back and the pipe is empty
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_coord();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? PIX_MAX : 0;
    return $urandom_range(0, PIX_MAX);
  endfunction

  function automatic logic [63:0] rand_vec(int span);
    return pack_vec($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                    $urandom_range(0, 2 * span) - span);
  endfunction

  initial begin
    int mode;
    rst_n = 1'b0; start = 1'b0; in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    no_gaps = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset: every ray is the zero vector
    send_pixel(0, 0); send_pixel(PIX_MAX, PIX_MAX);
    send_pixel(PIX_MAX, 0); send_pixel(0, PIX_MAX);
    drain();

    // single positive axis saturates to +1
    reg_write(REG_ULC, pack_vec(1024, 0, 0));
    send_pixel(0, 0); send_pixel(PIX_MAX, PIX_MAX);
    drain();

    // single negative axis reaches -1
    reg_write(REG_ULC, '0);
    reg_write(REG_POS, pack_vec(0, 1024, 0));
    send_pixel(1, 1);
    drain();

    // ordinary camera; corner pixel sits on the camera origin
    reg_write(REG_ULC, pack_vec(-2048, 1536, -1024));
    reg_write(REG_POS, pack_vec(-2048, 1536, -1024));
    reg_write(REG_RAX, pack_vec(1024, 0, 0));
    reg_write(REG_UAX, pack_vec(0, 1024, 0));
    reg_write(REG_HSTEP, 64'h4000);
    reg_write(REG_VSTEP, 64'h4000);
    send_pixel(0, 0); send_pixel(PIX_MAX, PIX_MAX);
    send_pixel(2048, 1536); send_pixel(PIX_MAX, 0);
    drain();

    // extreme components and steps, unused top bit set
    reg_write(REG_ULC, pack_vec(20'hFFFFF, -(1 << 20), -1) | (64'd1 << 63));
    reg_write(REG_POS, pack_vec(-(1 << 20), 20'hFFFFF, 0) | (64'd1 << 63));
    reg_write(REG_RAX, pack_vec(20'hFFFFF, 20'hFFFFF, 20'hFFFFF));
    reg_write(REG_UAX, pack_vec(-(1 << 20), -(1 << 20), -(1 << 20)));
    reg_write(REG_HSTEP, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_write(REG_VSTEP, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_write(BAD_REG_IDX, '0);
    send_pixel(PIX_MAX, PIX_MAX); send_pixel(0, 0);
    send_pixel(PIX_MAX, 0); send_pixel(0, PIX_MAX);
    drain();

    // random register sets, random pixels
    for (int ph = 0; ph < 8; ph++) begin
      mode = ph % 3;
      no_gaps = (ph == 2 || ph == 5);
      if (mode == 0) begin
        reg_write(REG_ULC, {$urandom, $urandom});
        reg_write(REG_POS, {$urandom, $urandom});
        reg_write(REG_RAX, {$urandom, $urandom});
        reg_write(REG_UAX, {$urandom, $urandom});
        reg_write(REG_HSTEP, {$urandom, $urandom});
        reg_write(REG_VSTEP, {$urandom, $urandom});
      end else begin
        reg_write(REG_ULC, rand_vec(4096));
        reg_write(REG_POS, (mode == 2) ? rand_vec(4) : rand_vec(4096));
        reg_write(REG_RAX, rand_vec(1024));
        reg_write(REG_UAX, rand_vec(1024));
        reg_write(REG_HSTEP, $urandom_range(0, 1 << 16));
        reg_write(REG_VSTEP, $urandom_range(0, 1 << 16));
      end
      if (ph == 7) reg_write(BAD_REG_IDX, {$urandom, $urandom});
      for (int i = 0; i < 244; i++) begin
        if (ph == 3 && i == 120) begin
          start <= 1'b0;
          while (pending != 0) @(posedge clk);
        end
        send_pixel(pick_coord(), pick_coord());
      end
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("camera_ray_direction_top: match");
    end else begin
      $display("camera_ray_direction_top: mismatch");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/crd_pkg.sv
src/camera_ray_direction_top.sv
dv/crd_ray_checker.sv
dv/tb_camera_ray_direction_top.sv
